[hdl/sqvt_pkg.sv]
// Shared types, constants and helpers for the sprite quad vertex transform.
// Used by sqvt_cell, the top level and the testbench; depends on nothing.
package sqvt_pkg;

    // Rotation unit: one step per cell
    localparam int CORDIC_STEPS = 20;
    localparam int CW           = 33;   // CORDIC x, y, z width
    localparam int CSW          = 27;   // sine and cosine after the Q2.24 floor
    localparam logic signed [CW-1:0] CORDIC_X0 = 33'sd652032874;

    localparam logic [31:0] ATAN_TURN [CORDIC_STEPS] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
        32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
        32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304
    };

    // Texture coordinate divider: one quotient bit per cell
    localparam int UV_BITS   = 17;
    localparam int DIV_STEPS = UV_BITS;
    localparam int DIM_BITS  = 13;
    localparam int REM_BITS  = 13;
    localparam logic [DIM_BITS-1:0] DIM_MAX = 13'd4096;
    localparam logic [UV_BITS-1:0]  UV_MAX  = '1;

    // Placed-mode offsets
    localparam int OFF_W = 38;
    localparam logic signed [OFF_W-1:0] OFF_LIM = 38'sh10_0000_0000;

    // Register indexes on the configuration port
    localparam logic [2:0] REG_TEX_LEFT   = 3'd0;
    localparam logic [2:0] REG_TEX_TOP    = 3'd1;
    localparam logic [2:0] REG_TEX_RIGHT  = 3'd2;
    localparam logic [2:0] REG_TEX_BOTTOM = 3'd3;
    localparam logic [2:0] REG_ANCHOR_X   = 3'd4;
    localparam logic [2:0] REG_ANCHOR_Y   = 3'd5;
    localparam logic [2:0] REG_UPP        = 3'd6;
    localparam logic [2:0] REG_TEX_DIMS   = 3'd7;

    // State of one item as it moves down the cell row.
    // Divider lanes: 0 left/u, 1 right/u, 2 top/v, 3 bottom/v.
    typedef struct packed {
        logic                            valid;
        logic                            rot;
        logic [1:0]                      quarter;
        logic signed [CW-1:0]            x;
        logic signed [CW-1:0]            y;
        logic signed [CW-1:0]            z;
        logic [3:0][REM_BITS-1:0]        rem;
        logic [3:0][UV_BITS-1:0]         quo;
        logic [3:0][UV_BITS-1:0]         lo;
        logic [3:0]                      sat;
    } cell_t;

    // Saturate to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [42:0] v);
        logic signed [31:0] r;
        if (v > 43'sd2147483647)
            r = 32'sh7FFF_FFFF;
        else if (v < -43'sd2147483648)
            r = 32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

[hdl/sqvt_cell.sv]
// One cell of the row: a CORDIC micro-rotation and, below DIV_STEPS, one
// restoring-division step on all four texture lanes. Depends on sqvt_pkg.
module sqvt_cell #(
    parameter int STEP = 0
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  sqvt_pkg::cell_t                  cin,
    input  logic [sqvt_pkg::DIM_BITS-1:0]    dim_w,
    input  logic [sqvt_pkg::DIM_BITS-1:0]    dim_h,
    output sqvt_pkg::cell_t                  cout
);

    sqvt_pkg::cell_t nxt;
    sqvt_pkg::cell_t data_reg;
    logic            valid_reg;
    logic signed [sqvt_pkg::CW-1:0]     xs;
    logic signed [sqvt_pkg::CW-1:0]     ys;
    logic [sqvt_pkg::REM_BITS:0]        trial [4];
    logic [sqvt_pkg::REM_BITS:0]        dm    [4];
    logic                               take  [4];

    // Micro-rotation and division step
    always_comb
    begin
        nxt = cin;
        xs  = cin.x >>> STEP;
        ys  = cin.y >>> STEP;
        if (!cin.z[sqvt_pkg::CW-1])
        begin
            nxt.x = cin.x - ys;
            nxt.y = cin.y + xs;
            nxt.z = cin.z - $signed({1'b0, sqvt_pkg::ATAN_TURN[STEP]});
        end
        else
        begin
            nxt.x = cin.x + ys;
            nxt.y = cin.y - xs;
            nxt.z = cin.z + $signed({1'b0, sqvt_pkg::ATAN_TURN[STEP]});
        end
        for (int j = 0; j < 4; j++)
        begin
            dm[j]    = {1'b0, ((j < 2) ? dim_w : dim_h)};
            trial[j] = {cin.rem[j], cin.lo[j][sqvt_pkg::UV_BITS-1]};
            take[j]  = (trial[j] >= dm[j]);
            if (STEP < sqvt_pkg::DIV_STEPS)
            begin
                nxt.rem[j] = take[j] ? sqvt_pkg::REM_BITS'(trial[j] - dm[j])
                                     : sqvt_pkg::REM_BITS'(trial[j]);
                nxt.quo[j] = {cin.quo[j][sqvt_pkg::UV_BITS-2:0], take[j]};
                nxt.lo[j]  = {cin.lo[j][sqvt_pkg::UV_BITS-2:0], 1'b0};
            end
        end
    end

    // Valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= cin.valid;
    end

    // Payload
    always_ff @(posedge clk)
    begin
        data_reg <= nxt;
    end

    always_comb
    begin
        cout       = data_reg;
        cout.valid = valid_reg;
    end

endmodule

[hdl/sqvt_wmul.sv]
// Two-stage signed multiplier: operand a split in two partial products,
// summed in the second stage. Standalone, no package use.
module sqvt_wmul #(
    parameter int A_W = 38,
    parameter int B_W = 27
) (
    input  logic                        clk,
    input  logic signed [A_W-1:0]       a,
    input  logic signed [B_W-1:0]       b,
    output logic signed [A_W+B_W-1:0]   p
);

    localparam int LO_W = A_W / 2;
    localparam int HI_W = A_W - LO_W;
    localparam int P_W  = A_W + B_W;

    logic signed [LO_W+B_W:0]   plo_reg;
    logic signed [HI_W+B_W-1:0] phi_reg;
    logic signed [P_W-1:0]      p_reg;

    // Partial products, then the shifted sum
    always_ff @(posedge clk)
    begin
        plo_reg <= $signed({1'b0, a[LO_W-1:0]}) * b;
        phi_reg <= $signed(a[A_W-1:LO_W]) * b;
        p_reg   <= (P_W'(phi_reg) <<< LO_W) + P_W'(plo_reg);
    end

    assign p = p_reg;

endmodule

[hdl/sqvt_delay.sv]
// Fixed-length shift line that carries side data alongside the cell row.
// Standalone, no package use.
module sqvt_delay #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic [WIDTH-1:0] din,
    output logic [WIDTH-1:0] dout
);

    logic [WIDTH-1:0] tap_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        tap_reg[0] <= din;
        for (int i = 1; i < DEPTH; i++)
            tap_reg[i] <= tap_reg[i-1];
    end

    assign dout = tap_reg[DEPTH-1];

endmodule

[hdl/sprite_quad_vertex_transform.sv]
// Top level of the sprite quad vertex transform.
// Depends on sqvt_pkg, sqvt_cell, sqvt_wmul and sqvt_delay.
//
// Usage:
//   A draw request is taken on a rising edge with start high and busy low.
//   Each request yields four corner beats, in order (a.x,a.y), (b.x,a.y),
//   (b.x,b.y), (a.x,b.y), on consecutive cycles, each marked by result_valid
//   for one cycle; last_corner flags the fourth. The receiver cannot stall.
//   A new request is taken only once busy falls again after a start beat,
//   which paces requests to the four result beats per request; up to seven
//   requests are in flight in the pipe.
//   The pipe is a row of 20 cells, each doing one CORDIC step for the
//   rotation and, in the first DIV_STEPS, one quotient bit of the texture
//   coordinate divisions, flanked by two-stage offset and rotation multipliers.
//   Configuration: cfg_valid/cfg_ready write channel, always ready; write
//   only while no request is in flight.
//   Reset: rst_n (asynchronous, active low) empties the pipe and loads the
//   register defaults: rectangle 0,0..256,256 px, anchor 128,128 px, one unit
//   per pixel, 256x256 texture.
module sprite_quad_vertex_transform #(
    parameter int FRAC_BITS  = 16,
    parameter int ANGLE_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               req_type,
    input  logic signed [31:0] quad_left,
    input  logic signed [31:0] quad_top,
    input  logic signed [31:0] quad_right,
    input  logic signed [31:0] quad_bottom,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [23:0] scale_x,
    input  logic signed [23:0] scale_y,
    input  logic [15:0]        angle,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [25:0]        cfg_data,
    output logic               result_valid,
    output logic [1:0]         corner_index,
    output logic signed [31:0] vertex_x,
    output logic signed [31:0] vertex_y,
    output logic [16:0]        tex_u,
    output logic [16:0]        tex_v,
    output logic               last_corner
);

    localparam int DVW   = FRAC_BITS + 12;
    localparam int OSH   = FRAC_BITS + 4;
    localparam int M1_W  = 42;
    localparam int M2_W  = M1_W + 24;
    localparam int R_W   = sqvt_pkg::OFF_W + sqvt_pkg::CSW;
    localparam int RX_W  = R_W + 1 - 24;
    localparam int NC    = sqvt_pkg::CORDIC_STEPS;
    localparam int UV_W  = sqvt_pkg::UV_BITS;

    typedef struct packed {
        logic               placed;
        logic signed [31:0] ql;
        logic signed [31:0] qt;
        logic signed [31:0] qr;
        logic signed [31:0] qb;
        logic signed [31:0] px;
        logic signed [31:0] py;
    } side_t;

    // Configuration registers
    logic [15:0] tex_left_reg, tex_top_reg, tex_right_reg, tex_bottom_reg;
    logic [15:0] anchor_x_reg, anchor_y_reg;
    logic [23:0] upp_reg;
    logic [25:0] tex_dims_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tex_left_reg   <= 16'd0;
            tex_top_reg    <= 16'd0;
            tex_right_reg  <= 16'd4096;
            tex_bottom_reg <= 16'd4096;
            anchor_x_reg   <= 16'd2048;
            anchor_y_reg   <= 16'd2048;
            upp_reg        <= 24'd65536;
            tex_dims_reg   <= 26'd2097408;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                sqvt_pkg::REG_TEX_LEFT:   tex_left_reg   <= cfg_data[15:0];
                sqvt_pkg::REG_TEX_TOP:    tex_top_reg    <= cfg_data[15:0];
                sqvt_pkg::REG_TEX_RIGHT:  tex_right_reg  <= cfg_data[15:0];
                sqvt_pkg::REG_TEX_BOTTOM: tex_bottom_reg <= cfg_data[15:0];
                sqvt_pkg::REG_ANCHOR_X:   anchor_x_reg   <= cfg_data[15:0];
                sqvt_pkg::REG_ANCHOR_Y:   anchor_y_reg   <= cfg_data[15:0];
                sqvt_pkg::REG_UPP:        upp_reg        <= cfg_data[23:0];
                sqvt_pkg::REG_TEX_DIMS:   tex_dims_reg   <= cfg_data;
                default:                  tex_dims_reg   <= tex_dims_reg;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    // Texture size, out-of-range values pulled to 1..4096
    logic [sqvt_pkg::DIM_BITS-1:0] w_raw, h_raw, dim_w, dim_h;
    logic [15:0] tedge [4];

    always_comb
    begin
        w_raw = tex_dims_reg[12:0];
        h_raw = tex_dims_reg[25:13];
        dim_w = (w_raw == '0) ? 13'd1 : ((w_raw > sqvt_pkg::DIM_MAX) ? sqvt_pkg::DIM_MAX : w_raw);
        dim_h = (h_raw == '0) ? 13'd1 : ((h_raw > sqvt_pkg::DIM_MAX) ? sqvt_pkg::DIM_MAX : h_raw);
        tedge[0] = tex_left_reg;
        tedge[1] = tex_right_reg;
        tedge[2] = tex_top_reg;
        tedge[3] = tex_bottom_reg;
    end

    // Request spacing: busy counts down after each start beat and blocks the next
    logic [1:0] busy_cnt_reg;
    logic       acc;

    assign acc  = start && !busy;
    assign busy = (busy_cnt_reg != 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_cnt_reg <= 2'd0;
        else if (acc)
            busy_cnt_reg <= 2'd3;
        else if (busy)
            busy_cnt_reg <= busy_cnt_reg - 2'd1;
    end

    // Input stage
    logic               s_valid_reg;
    side_t              s_side_reg;
    logic signed [23:0] s_sx_reg, s_sy_reg;
    logic [31:0]        s_phase_reg;
    logic               s_rot_reg;
    logic [31:0]        ang32;

    always_comb
    begin
        ang32 = 32'(angle) & ((32'd1 << ANGLE_BITS) - 32'd1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s_valid_reg <= 1'b0;
        else
            s_valid_reg <= acc;
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            s_side_reg  <= '{placed: req_type, ql: quad_left, qt: quad_top,
                             qr: quad_right, qb: quad_bottom, px: pos_x, py: pos_y};
            s_sx_reg    <= scale_x;
            s_sy_reg    <= scale_y;
            s_phase_reg <= ang32 << (32 - ANGLE_BITS);
            s_rot_reg   <= (ang32 != 32'd0);
        end
    end

    // Cell row entry: CORDIC start vector and divider set-up
    sqvt_pkg::cell_t chain [NC+1];
    logic [DVW-1:0]  dvd  [4];
    logic [DVW-1:0]  dhi  [4];

    always_comb
    begin
        chain[0]         = '0;
        chain[0].valid   = s_valid_reg;
        chain[0].rot     = s_rot_reg;
        chain[0].quarter = s_phase_reg[31:30];
        chain[0].x       = sqvt_pkg::CORDIC_X0;
        chain[0].y       = '0;
        chain[0].z       = $signed({3'b000, s_phase_reg[29:0]});
        for (int j = 0; j < 4; j++)
        begin
            dvd[j] = DVW'(tedge[j]) << (FRAC_BITS - 4);
            dhi[j] = dvd[j] >> UV_W;
            chain[0].sat[j] = (dhi[j] >= DVW'((j < 2) ? dim_w : dim_h));
            chain[0].rem[j] = sqvt_pkg::REM_BITS'(dhi[j]);
            chain[0].lo[j]  = dvd[j][UV_W-1:0];
        end
    end

    for (genvar g = 0; g < NC; g++)
    begin : g_cell
        sqvt_cell #(.STEP(g)) u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .cin   (chain[g]),
            .dim_w (dim_w),
            .dim_h (dim_h),
            .cout  (chain[g+1])
        );
    end

    // Row exit: quarter turn, floor to Q2.24, finish texture coordinates
    logic signed [sqvt_pkg::CW-1:0]  cc, ss;
    logic signed [sqvt_pkg::CSW-1:0] c_reg, s_reg;
    logic                            v22_reg, rot22_reg;
    logic [3:0][UV_W-1:0]            uv22_reg;

    always_comb
    begin
        case (chain[NC].quarter)
            2'd1:    begin cc = -chain[NC].y; ss =  chain[NC].x; end
            2'd2:    begin cc = -chain[NC].x; ss = -chain[NC].y; end
            2'd3:    begin cc =  chain[NC].y; ss = -chain[NC].x; end
            default: begin cc =  chain[NC].x; ss =  chain[NC].y; end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v22_reg <= 1'b0;
        else
            v22_reg <= chain[NC].valid;
    end

    always_ff @(posedge clk)
    begin
        c_reg     <= cc[sqvt_pkg::CW-1:6];
        s_reg     <= ss[sqvt_pkg::CW-1:6];
        rot22_reg <= chain[NC].rot;
        for (int j = 0; j < 4; j++)
            uv22_reg[j] <= chain[NC].sat[j] ? sqvt_pkg::UV_MAX : chain[NC].quo[j];
    end

    // Offsets: (edge - anchor) * units_per_pixel, then * scale
    logic signed [M1_W-1:0] o1_reg  [4];
    logic signed [23:0]     sc2_reg [4];
    logic signed [M2_W-1:0] p4      [4];
    logic signed [M2_W:0]   pn      [4];
    logic signed [M2_W:0]   psh     [4];
    logic signed [16:0]     dlt     [4];
    logic [3:0][sqvt_pkg::OFF_W-1:0] off5_reg;
    logic [3:0][sqvt_pkg::OFF_W-1:0] off22, off24;

    always_comb
    begin
        for (int j = 0; j < 4; j++)
            dlt[j] = $signed({1'b0, tedge[j]})
                   - $signed({1'b0, ((j < 2) ? anchor_x_reg : anchor_y_reg)});
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < 4; j++)
        begin
            o1_reg[j]  <= dlt[j] * $signed({1'b0, upp_reg});
            sc2_reg[j] <= (j < 2) ? s_sx_reg : s_sy_reg;
        end
    end

    for (genvar g = 0; g < 4; g++)
    begin : g_omul
        sqvt_wmul #(.A_W(M1_W), .B_W(24)) u_mul (
            .clk (clk),
            .a   (o1_reg[g]),
            .b   (sc2_reg[g]),
            .p   (p4[g])
        );
    end

    // y is negated before the floor; clamp to +-2^36
    always_comb
    begin
        for (int j = 0; j < 4; j++)
        begin
            pn[j]  = (j >= 2) ? -(($bits(pn[j]))'(p4[j])) : ($bits(pn[j]))'(p4[j]);
            psh[j] = pn[j] >>> OSH;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < 4; j++)
        begin
            if (psh[j] > ($bits(psh[j]))'(sqvt_pkg::OFF_LIM))
                off5_reg[j] <= sqvt_pkg::OFF_LIM;
            else if (psh[j] < -(($bits(psh[j]))'(sqvt_pkg::OFF_LIM)))
                off5_reg[j] <= -sqvt_pkg::OFF_LIM;
            else
                off5_reg[j] <= psh[j][sqvt_pkg::OFF_W-1:0];
        end
    end

    sqvt_delay #(.WIDTH(4*sqvt_pkg::OFF_W), .DEPTH(17)) u_off_dly (
        .clk (clk), .din (off5_reg), .dout (off22)
    );

    sqvt_delay #(.WIDTH(4*sqvt_pkg::OFF_W), .DEPTH(2)) u_off_dly2 (
        .clk (clk), .din (off22), .dout (off24)
    );

    // Rotation products: rp[j][0] = off*c, rp[j][1] = off*s
    logic signed [R_W-1:0] rp [4][2];

    for (genvar g = 0; g < 4; g++)
    begin : g_rmul
        sqvt_wmul #(.A_W(sqvt_pkg::OFF_W), .B_W(sqvt_pkg::CSW)) u_mc (
            .clk (clk), .a ($signed(off22[g])), .b (c_reg), .p (rp[g][0])
        );
        sqvt_wmul #(.A_W(sqvt_pkg::OFF_W), .B_W(sqvt_pkg::CSW)) u_ms (
            .clk (clk), .a ($signed(off22[g])), .b (s_reg), .p (rp[g][1])
        );
    end

    // Valid and rotate flag down to the corner stage
    logic v23_reg, v24_reg, v25_reg, rot23_reg, rot24_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v23_reg <= 1'b0;
            v24_reg <= 1'b0;
            v25_reg <= 1'b0;
        end
        else
        begin
            v23_reg <= v22_reg;
            v24_reg <= v23_reg;
            v25_reg <= v24_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        rot23_reg <= rot22_reg;
        rot24_reg <= rot23_reg;
    end

    // Corner offsets, rotated when the angle is nonzero
    logic signed [RX_W-1:0] rx_reg [4];
    logic signed [RX_W-1:0] ry_reg [4];
    logic signed [R_W:0]    tx     [4];
    logic signed [R_W:0]    ty     [4];
    int                     xi     [4];
    int                     yi     [4];

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            xi[k] = (k == 1 || k == 2) ? 1 : 0;
            yi[k] = (k >= 2) ? 3 : 2;
            tx[k] = ($bits(tx[k]))'(rp[xi[k]][0]) - ($bits(tx[k]))'(rp[yi[k]][1]);
            ty[k] = ($bits(ty[k]))'(rp[xi[k]][1]) + ($bits(ty[k]))'(rp[yi[k]][0]);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 4; k++)
        begin
            if (rot24_reg)
            begin
                rx_reg[k] <= tx[k][R_W:24];
                ry_reg[k] <= ty[k][R_W:24];
            end
            else
            begin
                rx_reg[k] <= RX_W'($signed(off24[xi[k]]));
                ry_reg[k] <= RX_W'($signed(off24[yi[k]]));
            end
        end
    end

    // Side data and texture coordinates aligned to the corner stage
    side_t                side25;
    logic [3:0][UV_W-1:0] uv25;

    sqvt_delay #(.WIDTH($bits(side_t)), .DEPTH(24)) u_side_dly (
        .clk (clk), .din (s_side_reg), .dout (side25)
    );

    sqvt_delay #(.WIDTH(4*UV_W), .DEPTH(3)) u_uv_dly (
        .clk (clk), .din (uv22_reg), .dout (uv25)
    );

    // Output buffer and corner sequencer
    logic signed [31:0]   vx_buf_reg [4];
    logic signed [31:0]   vy_buf_reg [4];
    logic [3:0][UV_W-1:0] uv_buf_reg;
    logic                 act_reg;
    logic [1:0]           cnt_reg;

    always_ff @(posedge clk)
    begin
        if (v25_reg)
        begin
            uv_buf_reg <= uv25;
            for (int k = 0; k < 4; k++)
            begin
                if (side25.placed)
                begin
                    vx_buf_reg[k] <= sqvt_pkg::sat32(43'(rx_reg[k]) + 43'(side25.px));
                    vy_buf_reg[k] <= sqvt_pkg::sat32(43'(ry_reg[k]) + 43'(side25.py));
                end
                else
                begin
                    vx_buf_reg[k] <= (k == 1 || k == 2) ? side25.qr : side25.ql;
                    vy_buf_reg[k] <= (k >= 2) ? side25.qb : side25.qt;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else if (v25_reg)
        begin
            act_reg <= 1'b1;
            cnt_reg <= 2'd0;
        end
        else if (act_reg)
        begin
            if (cnt_reg == 2'd3)
                act_reg <= 1'b0;
            cnt_reg <= cnt_reg + 2'd1;
        end
    end

    assign result_valid = act_reg;
    assign corner_index = cnt_reg;
    assign vertex_x     = vx_buf_reg[cnt_reg];
    assign vertex_y     = vy_buf_reg[cnt_reg];
    assign tex_u        = (cnt_reg == 2'd0 || cnt_reg == 2'd3) ? uv_buf_reg[0] : uv_buf_reg[1];
    assign tex_v        = (cnt_reg[1] == 1'b0) ? uv_buf_reg[2] : uv_buf_reg[3];
    assign last_corner  = act_reg && (cnt_reg == 2'd3);

endmodule

[hdl/sqvt_checker.sv]
// Port-level checks for the sprite quad vertex transform, bound to the top.
// Depends only on the top level's ports.
module sqvt_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       result_valid,
    input logic [1:0] corner_index,
    input logic       last_corner
);

    // A start beat closes the request port for the next cycle
    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy low right after a start beat");

    // Corners of one quad come on consecutive cycles in order
    a_corner_seq: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && corner_index != 2'd3) |=>
            (result_valid && corner_index == $past(corner_index) + 2'd1))
        else $error("corner beats not consecutive");

    // last_corner marks exactly the fourth corner beat
    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        last_corner == (result_valid && corner_index == 2'd3))
        else $error("last_corner mismatch");

    // After the fourth corner either idle or a new quad starts at corner 0
    a_quad_start: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && corner_index == 2'd3) |=> (!result_valid || corner_index == 2'd0))
        else $error("new quad does not start at corner 0");

endmodule

bind sprite_quad_vertex_transform sqvt_checker u_sqvt_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid),
    .corner_index (corner_index),
    .last_corner  (last_corner)
);

[dv/tb_sprite_quad_vertex_transform.sv]
// Self-checking testbench for sprite_quad_vertex_transform: directed and random draw
// requests across several register settings, each corner checked against a local model.
// Depends on sqvt_pkg and the RTL of the block.
module tb_sprite_quad_vertex_transform;

    typedef struct {
        logic               rtype;
        logic signed [31:0] ql, qt, qr, qb, px, py;
        logic signed [23:0] sx, sy;
        logic [15:0]        ang;
    } draw_req_t;

    typedef struct {
        logic [1:0]         idx;
        logic signed [31:0] x, y;
        logic [16:0]        u, v;
        logic               last;
    } corner_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic req_type = 1'b0;
    logic signed [31:0] quad_left = '0, quad_top = '0, quad_right = '0, quad_bottom = '0;
    logic signed [31:0] pos_x = '0, pos_y = '0;
    logic signed [23:0] scale_x = '0, scale_y = '0;
    logic [15:0] angle = '0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [2:0] cfg_index = '0;
    logic [25:0] cfg_data = '0;
    logic result_valid;
    logic [1:0] corner_index;
    logic signed [31:0] vertex_x, vertex_y;
    logic [16:0] tex_u, tex_v;
    logic last_corner;

    draw_req_t pending_reqs[$];
    corner_t   due_corners[$];
    int  errors = 0;
    int  idle_cycles = 0;
    int  gap = 0;
    bit  no_idle = 1'b0;

    // local copy of the register file
    longint rect_l, rect_t, rect_r, rect_b, anc_x, anc_y, upp, dims;

    sprite_quad_vertex_transform u_top (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [16:0] norm_coord(longint edge_px, longint dim);
        longint q;
        if (dim == 0) dim = 1;
        if (dim > 4096) dim = 4096;
        q = (edge_px << 12) / dim;
        return (q > 131071) ? 17'h1FFFF : q[16:0];
    endfunction

    function automatic longint placed_offset(longint edge_px, longint anc, longint scl,
                                             bit neg);
        longint p;
        p = (edge_px - anc) * upp * scl;
        if (neg) p = -p;
        p = p >>> 20;
        if (p > (64'sd1 <<< 36)) p = 64'sd1 <<< 36;
        if (p < -(64'sd1 <<< 36)) p = -(64'sd1 <<< 36);
        return p;
    endfunction

    // CORDIC within the quarter turn, quarter applied exactly, floored to Q2.24
    function automatic void cordic_sincos(input logic [31:0] phase,
                                          output longint c, output longint s);
        longint x, y, z, xs, ys, cc, ss;
        x = 652032874;
        y = 0;
        z = longint'(phase[29:0]);
        for (int i = 0; i < sqvt_pkg::CORDIC_STEPS; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0)
            begin
                x -= ys; y += xs; z -= longint'(sqvt_pkg::ATAN_TURN[i]);
            end
            else
            begin
                x += ys; y -= xs; z += longint'(sqvt_pkg::ATAN_TURN[i]);
            end
        end
        case (phase[31:30])
            2'd1:    begin cc = -y; ss = x;  end
            2'd2:    begin cc = -x; ss = -y; end
            2'd3:    begin cc = y;  ss = -x; end
            default: begin cc = x;  ss = y;  end
        endcase
        c = cc >>> 6;
        s = ss >>> 6;
    endfunction

    function automatic longint clip32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // four expected corners of one draw request
    function automatic void predict_quad(draw_req_t r);
        longint vx[4], vy[4], ax, ay, bx, by, c, s, tx, ty;
        logic [16:0] ua, ub, va, vb;
        corner_t e;
        ua = norm_coord(rect_l, dims & 64'h1FFF);
        ub = norm_coord(rect_r, dims & 64'h1FFF);
        va = norm_coord(rect_t, (dims >> 13) & 64'h1FFF);
        vb = norm_coord(rect_b, (dims >> 13) & 64'h1FFF);
        if (!r.rtype)
        begin
            ax = r.ql; ay = r.qt; bx = r.qr; by = r.qb;
        end
        else
        begin
            ax = placed_offset(rect_l, anc_x, r.sx, 1'b0);
            bx = placed_offset(rect_r, anc_x, r.sx, 1'b0);
            ay = placed_offset(rect_t, anc_y, r.sy, 1'b1);
            by = placed_offset(rect_b, anc_y, r.sy, 1'b1);
        end
        vx[0] = ax; vy[0] = ay; vx[1] = bx; vy[1] = ay;
        vx[2] = bx; vy[2] = by; vx[3] = ax; vy[3] = by;
        if (r.rtype)
        begin
            if (r.ang != 0)
            begin
                cordic_sincos({r.ang, 16'h0}, c, s);
                for (int k = 0; k < 4; k++)
                begin
                    tx = (vx[k] * c - vy[k] * s) >>> 24;
                    ty = (vx[k] * s + vy[k] * c) >>> 24;
                    vx[k] = tx;
                    vy[k] = ty;
                end
            end
            for (int k = 0; k < 4; k++)
            begin
                vx[k] += longint'(r.px);
                vy[k] += longint'(r.py);
            end
        end
        for (int k = 0; k < 4; k++)
        begin
            e.idx  = k[1:0];
            e.x    = 32'(clip32(vx[k]));
            e.y    = 32'(clip32(vy[k]));
            e.u    = (k == 0 || k == 3) ? ua : ub;
            e.v    = (k < 2) ? va : vb;
            e.last = (k == 3);
            due_corners.push_back(e);
        end
    endfunction

    // request driver: holds start until accepted, random gaps between beats
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            gap   <= 0;
        end
        else
        begin
            if (start && !busy)
                predict_quad(pending_reqs.pop_front());
            if (!start || !busy)
            begin
                if (gap > 0)
                begin
                    gap   <= gap - 1;
                    start <= 1'b0;
                end
                else if (pending_reqs.size() > 0 && !no_idle && $urandom_range(0, 4) == 0)
                begin
                    gap   <= $urandom_range(0, 2);
                    start <= 1'b0;
                end
                else if (pending_reqs.size() > 0)
                begin
                    start       <= 1'b1;
                    req_type    <= pending_reqs[0].rtype;
                    quad_left   <= pending_reqs[0].ql;
                    quad_top    <= pending_reqs[0].qt;
                    quad_right  <= pending_reqs[0].qr;
                    quad_bottom <= pending_reqs[0].qb;
                    pos_x       <= pending_reqs[0].px;
                    pos_y       <= pending_reqs[0].py;
                    scale_x     <= pending_reqs[0].sx;
                    scale_y     <= pending_reqs[0].sy;
                    angle       <= pending_reqs[0].ang;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // corner monitor and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || result_valid || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles > 3000)
            begin
                $display("sprite_quad_vertex_transform verification failed");
                $finish;
            end
        end
        if (rst_n && result_valid)
        begin
            if (due_corners.size() == 0)
            begin
                $display("%0t: unexpected corner beat idx=%0d", $time, corner_index);
                errors++;
            end
            else
            begin
                corner_t e;
                e = due_corners.pop_front();
                if (corner_index !== e.idx)
                begin
                    $display("%0t: corner_index exp %0d got %0d", $time, e.idx, corner_index);
                    errors++;
                end
                if (vertex_x !== e.x)
                begin
                    $display("%0t: vertex_x exp %0d got %0d", $time, e.x, vertex_x);
                    errors++;
                end
                if (vertex_y !== e.y)
                begin
                    $display("%0t: vertex_y exp %0d got %0d", $time, e.y, vertex_y);
                    errors++;
                end
                if (tex_u !== e.u)
                begin
                    $display("%0t: tex_u exp %0d got %0d", $time, e.u, tex_u);
                    errors++;
                end
                if (tex_v !== e.v)
                begin
                    $display("%0t: tex_v exp %0d got %0d", $time, e.v, tex_v);
                    errors++;
                end
                if (last_corner !== e.last)
                begin
                    $display("%0t: last_corner exp %0b got %0b", $time, e.last, last_corner);
                    errors++;
                end
            end
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [25:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            sqvt_pkg::REG_TEX_LEFT:   rect_l = data[15:0];
            sqvt_pkg::REG_TEX_TOP:    rect_t = data[15:0];
            sqvt_pkg::REG_TEX_RIGHT:  rect_r = data[15:0];
            sqvt_pkg::REG_TEX_BOTTOM: rect_b = data[15:0];
            sqvt_pkg::REG_ANCHOR_X:   anc_x  = data[15:0];
            sqvt_pkg::REG_ANCHOR_Y:   anc_y  = data[15:0];
            sqvt_pkg::REG_UPP:        upp    = data[23:0];
            default:                  dims   = data;
        endcase
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (pending_reqs.size() > 0 || start || due_corners.size() > 0)
            @(posedge clk);
    endtask

    function automatic draw_req_t make_req(logic rt, logic [15:0] a,
                                           logic signed [23:0] sx, logic signed [23:0] sy,
                                           logic signed [31:0] px, logic signed [31:0] py);
        draw_req_t r;
        r.rtype = rt; r.ang = a; r.sx = sx; r.sy = sy; r.px = px; r.py = py;
        r.ql = $urandom; r.qt = $urandom; r.qr = $urandom; r.qb = $urandom;
        return r;
    endfunction

    // random request: about half with modest scales, the rest full-range values
    function automatic draw_req_t random_req();
        draw_req_t r;
        r = make_req($urandom_range(0, 2) != 0, 16'($urandom), 24'($urandom),
                     24'($urandom), $urandom, $urandom);
        if ($urandom_range(0, 1))
        begin
            r.sx = $signed(24'($urandom_range(0, 262143))) - 24'sd131072;
            r.sy = $signed(24'($urandom_range(0, 262143))) - 24'sd131072;
            r.px = $signed(32'($urandom_range(0, 33554431))) - 32'sd16777216;
            r.py = $signed(32'($urandom_range(0, 33554431))) - 32'sd16777216;
        end
        if ($urandom_range(0, 5) == 0)
            r.ang = '0;
        return r;
    endfunction

    initial
    begin
        draw_req_t r;
        rect_l = 0; rect_t = 0; rect_r = 4096; rect_b = 4096;
        anc_x = 2048; anc_y = 2048; upp = 65536; dims = 2097408;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed: explicit extremes, placed at every quarter, saturation
        r = make_req(1'b0, 16'h0, '0, '0, '0, '0);
        r.ql = 32'sh7FFF_FFFF; r.qt = 32'sh8000_0000; r.qr = '0; r.qb = -1;
        pending_reqs.push_back(r);
        r.ql = 32'sh8000_0000; r.qt = 32'sh7FFF_FFFF; r.qr = -1; r.qb = '0;
        pending_reqs.push_back(r);
        pending_reqs.push_back(make_req(1'b1, 16'h0, 24'sh010000, 24'sh010000, '0, '0));
        pending_reqs.push_back(make_req(1'b1, 16'h0001, 24'sh010000, 24'sh010000, '0, '0));
        pending_reqs.push_back(make_req(1'b1, 16'h4000, 24'sh010000, 24'sh010000, '0, '0));
        pending_reqs.push_back(make_req(1'b1, 16'h8000, 24'sh010000, 24'sh010000, '0, '0));
        pending_reqs.push_back(make_req(1'b1, 16'hC000, 24'sh010000, 24'sh010000, '0, '0));
        pending_reqs.push_back(make_req(1'b1, 16'hFFFF, 24'sh010000, 24'sh010000, '0, '0));
        pending_reqs.push_back(make_req(1'b1, 16'h2000, 24'sh7FFFFF, 24'sh800000,
                                        32'sh7FFF_FFFF, 32'sh8000_0000));
        pending_reqs.push_back(make_req(1'b1, 16'h0, 24'sh800000, 24'sh7FFFFF,
                                        32'sh8000_0000, 32'sh7FFF_FFFF));
        pending_reqs.push_back(make_req(1'b1, 16'h0, 24'sh7FFFFF, 24'sh7FFFFF,
                                        32'sh7FFF_F000, 32'sh7FFF_F000));
        pending_reqs.push_back(make_req(1'b1, 16'h6000, '0, '0, 32'sh1234_5678, -32'sd5));
        drain();

        // register extremes, then random settings
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0:
                begin
                    write_reg(sqvt_pkg::REG_TEX_LEFT, 26'hFFFF);
                    write_reg(sqvt_pkg::REG_TEX_TOP, 26'h0);
                    write_reg(sqvt_pkg::REG_TEX_RIGHT, 26'h0);
                    write_reg(sqvt_pkg::REG_TEX_BOTTOM, 26'hFFFF);
                    write_reg(sqvt_pkg::REG_ANCHOR_X, 26'h0);
                    write_reg(sqvt_pkg::REG_ANCHOR_Y, 26'hFFFF);
                    write_reg(sqvt_pkg::REG_UPP, 26'hFFFFFF);
                    write_reg(sqvt_pkg::REG_TEX_DIMS, 26'd8193);
                end
                1:
                begin
                    write_reg(sqvt_pkg::REG_TEX_LEFT, 26'h0);
                    write_reg(sqvt_pkg::REG_TEX_TOP, 26'hFFFF);
                    write_reg(sqvt_pkg::REG_ANCHOR_X, 26'hFFFF);
                    write_reg(sqvt_pkg::REG_ANCHOR_Y, 26'h0);
                    write_reg(sqvt_pkg::REG_UPP, 26'h0);
                    write_reg(sqvt_pkg::REG_TEX_DIMS, 26'd33558528);
                end
                2:
                begin
                    write_reg(sqvt_pkg::REG_UPP, 26'h000100);
                    write_reg(sqvt_pkg::REG_TEX_DIMS, 26'h0);
                    write_reg(sqvt_pkg::REG_TEX_RIGHT, 26'h1000);
                    write_reg(sqvt_pkg::REG_TEX_BOTTOM, 26'h0800);
                end
                3:
                    write_reg(sqvt_pkg::REG_TEX_DIMS, 26'h3FFFFFF);
                default:
                begin
                    for (int i = 0; i < 8; i++)
                        write_reg(3'(i), 26'($urandom));
                end
            endcase
            for (int i = 0; i < 36; i++)
            begin
                if (ph == 5 && i == 20)
                begin
                    while (pending_reqs.size() > 0) @(posedge clk);
                    no_idle = 1'b1;
                end
                pending_reqs.push_back(random_req());
            end
            drain();
        end

        repeat (40) @(posedge clk);
        if (errors == 0)
            $display("sprite_quad_vertex_transform verification clean");
        else
            $display("sprite_quad_vertex_transform verification failed");
        $finish;
    end

endmodule
